// ----- rtl/playfair_digraph_cipher_unit_assert.svh -----
// assertion macros used by the checker file
`ifndef PLAYFAIR_DIGRAPH_CIPHER_UNIT_ASSERT_SVH
`define PLAYFAIR_DIGRAPH_CIPHER_UNIT_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define PDC_ASSERT_NOW(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("pdc assertion failed");

// next-cycle implication, disabled while in reset
`define PDC_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("pdc assertion failed");

`endif

// ----- rtl/pdc_pkg.sv -----
// ----------------------------------------------------------------------------
// pdc_pkg
// shared types, constants and helpers of the playfair digraph cipher unit
// ----------------------------------------------------------------------------
package pdc_pkg;

    localparam int SIDE      = 5;
    localparam int CELLS     = 25;
    localparam int CELL_W    = 5;
    localparam int POS_W     = 3;
    localparam int SQUARE_W  = 50;
    localparam int LAST_W    = 25;
    localparam int CFG_IDX_W = 2;
    localparam int DATA_W    = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROWS_TOP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS_MID = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_LAST = 2'd2;

    typedef logic [CELL_W-1:0] letter_t;

    // cell k = row*5 + col, cell 0 in the lowest bits
    typedef logic [CELLS-1:0][CELL_W-1:0] square_t;

    // position of a letter found by a lookup lane
    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
    } pos_t;

    // one step along a row or column with wrap, forward or back
    function automatic logic [POS_W-1:0] wrap_step(input logic [POS_W-1:0] v,
                                                   input logic dec);
        logic [POS_W-1:0] r;
        if (dec)
        begin
            r = (v == 3'd0) ? 3'd4 : v - 3'd1;
        end
        else
        begin
            r = (v == 3'd4) ? 3'd0 : v + 3'd1;
        end
        return r;
    endfunction

    function automatic logic [CELL_W-1:0] cell_index(input logic [POS_W-1:0] row,
                                                     input logic [POS_W-1:0] col);
        return {row, 2'b00} + 5'(row) + 5'(col);
    endfunction

endpackage

// ----- rtl/pdc_lane.sv -----
// ----------------------------------------------------------------------------
// pdc_lane
// looks one letter up in the key square, first match in row-major order
// ----------------------------------------------------------------------------
module pdc_lane
(
    input  pdc_pkg::letter_t letter,
    input  pdc_pkg::square_t square,
    output pdc_pkg::pos_t    pos
);
    import pdc_pkg::*;

    logic [CELLS-1:0] hit;
    logic [CELLS-1:0] first_hit;

    always_comb
    begin
        for (int k = 0; k < CELLS; k++)
        begin
            hit[k] = (square[k] == letter);
        end
    end

    // isolate the lowest set bit
    assign first_hit = hit & (~hit + 25'd1);

    always_comb
    begin
        pos.found = |hit;
        pos.row   = '0;
        pos.col   = '0;
        for (int k = 0; k < CELLS; k++)
        begin
            pos.row = pos.row | (first_hit[k] ? POS_W'(k / SIDE) : 3'd0);
            pos.col = pos.col | (first_hit[k] ? POS_W'(k % SIDE) : 3'd0);
        end
    end

endmodule

// ----- rtl/pdc_merge.sv -----
// ----------------------------------------------------------------------------
// pdc_merge
// combines the two lane positions by the row, column or rectangle rule
// ----------------------------------------------------------------------------
module pdc_merge
(
    input  logic             dec,
    input  pdc_pkg::pos_t    pos_a,
    input  pdc_pkg::pos_t    pos_b,
    input  pdc_pkg::square_t square,
    output pdc_pkg::letter_t out_first,
    output pdc_pkg::letter_t out_second,
    output logic             letter_missing
);
    import pdc_pkg::*;

    logic             same_row;
    logic             same_col;
    logic [POS_W-1:0] row_a;
    logic [POS_W-1:0] col_a;
    logic [POS_W-1:0] row_b;
    logic [POS_W-1:0] col_b;

    assign same_row       = (pos_a.row == pos_b.row);
    assign same_col       = (pos_a.col == pos_b.col);
    assign letter_missing = !(pos_a.found && pos_b.found);

    always_comb
    begin
        priority if (same_row)
        begin
            row_a = pos_a.row;
            col_a = wrap_step(pos_a.col, dec);
            row_b = pos_b.row;
            col_b = wrap_step(pos_b.col, dec);
        end
        else if (same_col)
        begin
            row_a = wrap_step(pos_a.row, dec);
            col_a = pos_a.col;
            row_b = wrap_step(pos_b.row, dec);
            col_b = pos_b.col;
        end
        else
        begin
            // rectangle corners
            row_a = pos_a.row;
            col_a = pos_b.col;
            row_b = pos_b.row;
            col_b = pos_a.col;
        end
    end

    assign out_first  = letter_missing ? '0 : square[cell_index(row_a, col_a)];
    assign out_second = letter_missing ? '0 : square[cell_index(row_b, col_b)];

endmodule

// ----- rtl/playfair_digraph_cipher_unit.sv -----
// ----------------------------------------------------------------------------
// playfair_digraph_cipher_unit
// encrypts or decrypts one playfair digraph per beat against a 5x5 key square
// ----------------------------------------------------------------------------
// One digraph enters per clock, one beat per cycle as long as the output is
// not stalled; it passes through the two pipeline registers (lane positions,
// then the output register). Two lookup lanes each compare their
// letter against all 25 cells at once and pick the first match in row-major
// order; the merge stage applies the same-row, same-column or rectangle rule
// and reads the result cells. A letter not held in the square gives zero
// letters and raises the missing flag in tuser. The key square is loaded
// through the cfg channel (index 0 rows 0-1, index 1 rows 2-3, index 2 row 4,
// five bits per cell, cell 0 lowest); cfg is always ready, a write to index 3
// is dropped, and the square must only be changed while the pipeline is empty.
// The pipeline stalls stage by stage, so a new beat is still taken while a
// result waits at the output, as long as the middle stage is free.
module playfair_digraph_cipher_unit
(
    input  logic                              clk,
    input  logic                              rst_n,

    // input digraph stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [pdc_pkg::DATA_W-1:0]        s_tdata,   // first_letter[4:0], second_letter[9:5]
    input  logic [0:0]                        s_tuser,   // op[0]: 0 encrypt, 1 decrypt

    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [pdc_pkg::DATA_W-1:0]        m_tdata,   // out_first[4:0], out_second[9:5]
    output logic [0:0]                        m_tuser,   // letter_missing[0]

    // key square configuration
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pdc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pdc_pkg::SQUARE_W-1:0]      cfg_data
);
    import pdc_pkg::*;

    // configuration registers
    logic [SQUARE_W-1:0] rows_top_reg;
    logic [SQUARE_W-1:0] rows_mid_reg;
    logic [LAST_W-1:0]   row_last_reg;
    square_t             square;

    // lane stage
    pos_t                pos_a;
    pos_t                pos_b;
    pos_t                pos_a_reg;
    pos_t                pos_b_reg;
    logic                dec_reg;
    logic                lane_valid_reg;

    // merge stage
    letter_t             mrg_first;
    letter_t             mrg_second;
    logic                mrg_missing;
    letter_t             out_first_reg;
    letter_t             out_second_reg;
    logic                out_missing_reg;
    logic                out_valid_reg;

    logic                out_adv;
    logic                lane_adv;

    // ---------------- configuration ----------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_top_reg <= '0;
            rows_mid_reg <= '0;
            row_last_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_ROWS_TOP: rows_top_reg <= cfg_data;
                REG_ROWS_MID: rows_mid_reg <= cfg_data;
                REG_ROW_LAST: row_last_reg <= cfg_data[LAST_W-1:0];
                default:      ; // unused index, write dropped
            endcase
        end
    end

    // cells 0..9 from the top word, 10..19 from the middle, 20..24 from the last
    assign square = {row_last_reg, rows_mid_reg, rows_top_reg};

    // ---------------- flow control ----------------
    // each stage moves on when the stage after it is empty or moving
    assign out_adv  = !out_valid_reg || m_tready;
    assign lane_adv = !lane_valid_reg || out_adv;
    assign s_tready = lane_adv;

    // ---------------- lookup lanes ----------------
    pdc_lane u_lane_a
    (
        .letter (s_tdata[CELL_W-1:0]),
        .square (square),
        .pos    (pos_a)
    );

    pdc_lane u_lane_b
    (
        .letter (s_tdata[2*CELL_W-1:CELL_W]),
        .square (square),
        .pos    (pos_b)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lane_valid_reg <= 1'b0;
        end
        else if (lane_adv)
        begin
            lane_valid_reg <= s_tvalid;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (lane_adv && s_tvalid)
        begin
            pos_a_reg <= pos_a;
            pos_b_reg <= pos_b;
            dec_reg   <= s_tuser[0];
        end
    end

    // ---------------- merge ----------------
    pdc_merge u_merge
    (
        .dec            (dec_reg),
        .pos_a          (pos_a_reg),
        .pos_b          (pos_b_reg),
        .square         (square),
        .out_first      (mrg_first),
        .out_second     (mrg_second),
        .letter_missing (mrg_missing)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_adv)
        begin
            out_valid_reg <= lane_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_adv && lane_valid_reg)
        begin
            out_first_reg   <= mrg_first;
            out_second_reg  <= mrg_second;
            out_missing_reg <= mrg_missing;
        end
    end

    // ---------------- outputs ----------------
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(DATA_W - 2*CELL_W)'(0), out_second_reg, out_first_reg};
    assign m_tuser  = out_missing_reg;

endmodule

// ----- rtl/pdc_checker.sv -----
// ----------------------------------------------------------------------------
// pdc_checker
// port-level checks on the playfair digraph cipher unit
// ----------------------------------------------------------------------------
`include "playfair_digraph_cipher_unit_assert.svh"

module pdc_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [pdc_pkg::DATA_W-1:0]    s_tdata,
    input logic [0:0]                    s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [pdc_pkg::DATA_W-1:0]    m_tdata,
    input logic [0:0]                    m_tuser,
    input logic                          cfg_valid,
    input logic                          cfg_ready,
    input logic [pdc_pkg::CFG_IDX_W-1:0] cfg_index,
    input logic [pdc_pkg::SQUARE_W-1:0]  cfg_data
);
    import pdc_pkg::*;

    // a stalled result holds
    `PDC_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // input only backs up when the output is full and stalled
    `PDC_ASSERT_NOW(a_in_stall, clk, rst_n, !s_tready, m_tvalid && !m_tready)

    // a missing letter gives zero letters
    `PDC_ASSERT_NOW(a_missing_zero, clk, rst_n, m_tvalid && m_tuser[0], m_tdata[2*CELL_W-1:0] == '0)

endmodule

bind playfair_digraph_cipher_unit pdc_checker u_pdc_checker (.*);

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the playfair digraph cipher unit
// ----------------------------------------------------------------------------
// Digraph beats go in on the s side with random gaps. Result beats are taken
// on the m side with random stalls. A scoreboard object keeps its own copy of
// the key square and works out the expected result of every accepted digraph.
// Each result beat is checked field by field against the oldest one still
// waiting. The run loads a series of key squares: reset, a textbook square,
// shuffled squares, squares full of repeats, all ones, all zeros and arbitrary
// codes. It then ends on a pass or fail line.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import pdc_pkg::*;

    // selector values carried in s_tuser
    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    // no register sits behind this index, so a write to it must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    localparam letter_t TOP_CODE   = 5'd31;
    localparam int      IDLE_LIMIT = 5000;

    // ways of filling a random key square
    typedef enum int
    {
        FILL_DISTINCT,
        FILL_CLUSTERED,
        FILL_ANY
    } square_fill_t;

    typedef struct packed
    {
        letter_t out_first;
        letter_t out_second;
        logic    letter_missing;
    } cipher_result_t;

    // ------------------------------------------------------------------------
    // scoreboard: key square copy, digraph predictor and result queue
    // ------------------------------------------------------------------------
    class digraph_scoreboard;
        logic [SQUARE_W-1:0] rows_top;
        logic [SQUARE_W-1:0] rows_mid;
        logic [LAST_W-1:0]   row_last;
        cipher_result_t      awaited[$];
        int n_errors;
        int n_digraphs;
        int n_same_row;
        int n_same_col;
        int n_corner;
        int n_missing;

        function new();
            rows_top   = '0;
            rows_mid   = '0;
            row_last   = '0;
            n_errors   = 0;
            n_digraphs = 0;
            n_same_row = 0;
            n_same_col = 0;
            n_corner   = 0;
            n_missing  = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [SQUARE_W-1:0] data);
            case (idx)
                REG_ROWS_TOP: rows_top = data;
                REG_ROWS_MID: rows_mid = data;
                REG_ROW_LAST: row_last = data[LAST_W-1:0];
                default: ;
            endcase
        endfunction

        // row and column wrap round the side of the square
        function letter_t cell_code(int row, int col);
            int k;
            k = (row % SIDE) * SIDE + (col % SIDE);
            if (k < 2 * SIDE)
                return rows_top[CELL_W*k +: CELL_W];
            else if (k < 4 * SIDE)
                return rows_mid[CELL_W*(k - 2*SIDE) +: CELL_W];
            return row_last[CELL_W*(k - 4*SIDE) +: CELL_W];
        endfunction

        // the first hit in row-major order wins when a code is held twice
        function bit locate_letter(letter_t l, output int row, output int col);
            row = 0;
            col = 0;
            for (int k = 0; k < CELLS; k++)
            begin
                if (cell_code(k / SIDE, k % SIDE) == l)
                begin
                    row = k / SIDE;
                    col = k % SIDE;
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        function void note_digraph(logic dec, letter_t a, letter_t b);
            cipher_result_t want;
            int  ra, ca, rb, cb;
            int  stride;
            bit  fa, fb;
            stride = (dec == OP_DECRYPT) ? SIDE - 1 : 1;
            fa = locate_letter(a, ra, ca);
            fb = locate_letter(b, rb, cb);
            want = '0;
            n_digraphs++;
            if (!fa || !fb)
            begin
                want.letter_missing = 1'b1;
                n_missing++;
            end
            else if (ra == rb)
            begin
                want.out_first  = cell_code(ra, ca + stride);
                want.out_second = cell_code(rb, cb + stride);
                n_same_row++;
            end
            else if (ca == cb)
            begin
                want.out_first  = cell_code(ra + stride, ca);
                want.out_second = cell_code(rb + stride, cb);
                n_same_col++;
            end
            else
            begin
                want.out_first  = cell_code(ra, cb);
                want.out_second = cell_code(rb, ca);
                n_corner++;
            end
            awaited.push_back(want);
        endfunction

        task report_mismatch(string what);
            n_errors++;
            if (n_errors <= 40)
                $display("tb_top: mismatch at %0t: %s", $realtime, what);
        endtask

        task check_result(letter_t got_first, letter_t got_second, logic got_missing);
            cipher_result_t want;
            if (awaited.size() == 0)
            begin
                report_mismatch("result beat with no digraph awaiting it");
                return;
            end
            want = awaited.pop_front();
            if (got_first !== want.out_first)
                report_mismatch($sformatf("out_first %0d, wanted %0d",
                                          got_first, want.out_first));
            if (got_second !== want.out_second)
                report_mismatch($sformatf("out_second %0d, wanted %0d",
                                          got_second, want.out_second));
            if (got_missing !== want.letter_missing)
                report_mismatch($sformatf("letter_missing %0b, wanted %0b",
                                          got_missing, want.letter_missing));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // clock, stimulus signals and the block itself
    // ------------------------------------------------------------------------
    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [DATA_W-1:0]      s_tdata;   // first_letter[4:0], second_letter[9:5]
    logic [0:0]             s_tuser;   // op[0]
    logic                   m_tvalid;
    logic                   m_tready;
    logic [DATA_W-1:0]      m_tdata;   // out_first[4:0], out_second[9:5]
    logic [0:0]             m_tuser;   // letter_missing[0]
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [SQUARE_W-1:0]    cfg_data;

    digraph_scoreboard sb;
    bit calm;          // while set neither side idles
    int n_loads;
    int idle_cycles;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    playfair_digraph_cipher_unit dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------------
    // helpers
    // ------------------------------------------------------------------------

    // idle length: mostly none or short, now and then a long one
    function automatic int stall_length();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic letter_t code_of(byte ch);
        return letter_t'(ch - "A");
    endfunction

    function automatic square_t square_from_text(string s);
        square_t sq;
        for (int k = 0; k < CELLS; k++)
            sq[k] = code_of(s[k]);
        return sq;
    endfunction

    function automatic square_t random_square(square_fill_t fill);
        square_t sq;
        int      pool[32];
        int      j, t;
        for (int i = 0; i < 32; i++)
            pool[i] = i;
        // shuffle so that a distinct square takes 25 of the 32 codes
        for (int i = 31; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            t = pool[i];
            pool[i] = pool[j];
            pool[j] = t;
        end
        for (int k = 0; k < CELLS; k++)
        begin
            case (fill)
                FILL_DISTINCT:  sq[k] = letter_t'(pool[k]);
                FILL_CLUSTERED: sq[k] = letter_t'($urandom_range(0, 7));
                default:        sq[k] = letter_t'($urandom_range(0, 31));
            endcase
        end
        return sq;
    endfunction

    // mostly codes held in the current square, so the cipher rules get hit
    function automatic letter_t pick_letter();
        if ($urandom_range(0, 3) != 0)
            return sb.cell_code($urandom_range(0, SIDE - 1), $urandom_range(0, SIDE - 1));
        return letter_t'($urandom_range(0, 31));
    endfunction

    // ------------------------------------------------------------------------
    // drivers: everything changes on the falling edge
    // ------------------------------------------------------------------------
    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [SQUARE_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    // junk above row 4 and a dummy write to the spare index must both be ignored
    task automatic load_square(square_t sq);
        cfg_write(REG_ROWS_TOP, sq[9:0]);
        cfg_write(REG_ROWS_MID, sq[19:10]);
        cfg_write(REG_ROW_LAST, {25'($urandom), sq[24:20]});
        cfg_write(REG_UNUSED, SQUARE_W'({$urandom, $urandom}));
        @(negedge clk);
        cfg_valid <= 1'b0;
        n_loads++;
    endtask

    task automatic send_digraph(logic dec, letter_t a, letter_t b);
        int gap;
        gap = stall_length();
        repeat (gap)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= DATA_W'({b, a});
        s_tuser  <= dec;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // let the pipeline empty out, until no result is still awaited
    task automatic drain_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.awaited.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic run_random(int count);
        for (int i = 0; i < count; i++)
        begin
            if (i % 64 == 0)
                calm = ($urandom_range(0, 3) == 0);
            send_digraph(1'($urandom_range(0, 1)), pick_letter(), pick_letter());
        end
        calm = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // result side pacing: bursts of ready broken by stalls
    // ------------------------------------------------------------------------
    initial
    begin : sink_pacing
        int burst;
        int hold;
        m_tready = 1'b0;
        forever
        begin
            burst = $urandom_range(1, 12);
            repeat (burst)
            begin
                @(negedge clk);
                m_tready <= 1'b1;
            end
            hold = stall_length();
            repeat (hold)
            begin
                @(negedge clk);
                m_tready <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor and watchdog, sampled on the rising edge
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index, cfg_data);
            if (s_tvalid && s_tready)
                sb.note_digraph(s_tuser[0], s_tdata[4:0], s_tdata[9:5]);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata[4:0], m_tdata[9:5], m_tuser[0]);
        end
        if ((cfg_valid && cfg_ready) || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb_top: no beat for %0d cycles, %0d results outstanding",
                     IDLE_LIMIT, sb.awaited.size());
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        sb          = new();
        calm        = 1'b0;
        n_loads     = 0;
        idle_cycles = 0;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        // square straight out of reset: every cell holds A
        send_digraph(OP_ENCRYPT, code_of("A"), code_of("A"));
        send_digraph(OP_DECRYPT, code_of("A"), code_of("A"));
        send_digraph(OP_ENCRYPT, code_of("Z"), code_of("A"));
        send_digraph(OP_DECRYPT, TOP_CODE, TOP_CODE);
        drain_results();

        // textbook square, J left out
        load_square(square_from_text("PLAYFIREXMBCDGHKNOQSTUVWZ"));
        // same row, wrapping off the right edge and then the left
        send_digraph(OP_ENCRYPT, code_of("Y"), code_of("F"));
        send_digraph(OP_DECRYPT, code_of("P"), code_of("L"));
        // same column, wrapping past the bottom and the top
        send_digraph(OP_ENCRYPT, code_of("F"), code_of("Z"));
        send_digraph(OP_DECRYPT, code_of("F"), code_of("Z"));
        // rectangle corners
        send_digraph(OP_ENCRYPT, code_of("H"), code_of("I"));
        send_digraph(OP_DECRYPT, code_of("H"), code_of("I"));
        // doubled letter falls under the row rule
        send_digraph(OP_ENCRYPT, code_of("E"), code_of("E"));
        send_digraph(OP_DECRYPT, code_of("E"), code_of("E"));
        // letter not in the square, either side
        send_digraph(OP_ENCRYPT, code_of("J"), code_of("A"));
        send_digraph(OP_DECRYPT, code_of("A"), code_of("J"));
        // codes beyond Z
        send_digraph(OP_ENCRYPT, TOP_CODE, code_of("A"));
        send_digraph(OP_DECRYPT, code_of("A"), letter_t'(26));
        // lowest and highest letters
        send_digraph(OP_ENCRYPT, code_of("Z"), code_of("A"));
        send_digraph(OP_DECRYPT, code_of("A"), code_of("Z"));

        run_random(100);
        // hold off until the pipeline is empty, then carry on
        drain_results();
        run_random(100);
        drain_results();

        load_square(random_square(FILL_DISTINCT));
        run_random(200);
        drain_results();

        // many repeated codes, so the first match in row-major order matters
        load_square(random_square(FILL_CLUSTERED));
        run_random(150);
        drain_results();

        load_square('1);
        send_digraph(OP_ENCRYPT, TOP_CODE, TOP_CODE);
        send_digraph(OP_DECRYPT, TOP_CODE, code_of("A"));
        run_random(60);
        drain_results();

        load_square('0);
        run_random(60);
        drain_results();

        load_square(random_square(FILL_DISTINCT));
        run_random(120);
        drain_results();
        run_random(130);
        drain_results();

        load_square(random_square(FILL_ANY));
        run_random(150);
        drain_results();

        if (sb.awaited.size() != 0)
            sb.report_mismatch($sformatf("%0d results never arrived", sb.awaited.size()));

        $display("tb_top: %0d digraphs checked against %0d key squares",
                 sb.n_digraphs, n_loads + 1);
        $display("tb_top: same row %0d, same column %0d, rectangle %0d, letter missing %0d",
                 sb.n_same_row, sb.n_same_col, sb.n_corner, sb.n_missing);
        if (sb.n_errors == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
